// ===== sv/frs_pkg.sv =====
// Shared types, character constants and saturating helpers for the FASTA record splitter.
// No dependencies; used by every module of the block.
package frs_pkg;

	localparam int COUNT_BITS = 32;
	localparam int OUT_BITS   = 32;
	localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_GT      = 8'h3E;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		CLS_SKIP    = 3'd0,
		CLS_NEWLINE = 3'd1,
		CLS_START   = 3'd2,
		CLS_HEADER  = 3'd3,
		CLS_SEQ     = 3'd4,
		CLS_DROP    = 3'd5,
		CLS_END     = 3'd6
	} cls_t;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [OUT_BITS-1:0]   out_t;

	typedef struct packed {
		logic in_header_line;
		logic at_line_start;
		logic record_open;
		cnt_t record_counter;
		cnt_t header_length;
		cnt_t sequence_length;
	} st_t;

	typedef struct packed {
		cls_t       byte_class;
		logic [7:0] out_byte;
		out_t       record_index;
		out_t       char_offset;
		logic       closed_valid;
		out_t       closed_header_length;
		out_t       closed_sequence_length;
		out_t       total_records;
	} res_t;

	localparam st_t ST_RESET = '{
		in_header_line:  1'b0,
		at_line_start:   1'b1,
		record_open:     1'b0,
		record_counter:  '0,
		header_length:   '0,
		sequence_length: '0
	};

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

	// clamp a counter to the output field width
	function automatic out_t out_sat(cnt_t v);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		if ((w >> OUT_BITS) != '0)
			return '1;
		return w[OUT_BITS-1:0];
	endfunction

endpackage

// ===== sv/frs_classify.sv =====
// Byte classifier and next-state logic for the FASTA record splitter.
// Pure combinational; depends on frs_pkg.
module frs_classify (
	input  frs_pkg::st_t  st,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	output frs_pkg::st_t  st_next,
	output frs_pkg::res_t res
);

	frs_pkg::cnt_t cur_index;

	assign cur_index = (st.record_open && st.record_counter != '0) ?
		st.record_counter - frs_pkg::cnt_t'(1) : '0;

	always_comb begin
		st_next = st;
		res = '{
			byte_class:             frs_pkg::CLS_DROP,
			out_byte:               data_byte,
			record_index:           '0,
			char_offset:            '0,
			closed_valid:           1'b0,
			closed_header_length:   '0,
			closed_sequence_length: '0,
			total_records:          '0
		};

		if (kind == frs_pkg::KIND_END) begin
			res.byte_class = frs_pkg::CLS_END;
			res.out_byte = '0;
			if (st.record_open) begin
				res.record_index = frs_pkg::out_sat(cur_index);
				res.closed_valid = 1'b1;
				res.closed_header_length = frs_pkg::out_sat(st.header_length);
				res.closed_sequence_length = frs_pkg::out_sat(st.sequence_length);
			end
			res.total_records = frs_pkg::out_sat(st.record_counter);
			st_next = frs_pkg::ST_RESET;
		end else if (data_byte == frs_pkg::CHAR_NEWLINE) begin
			res.byte_class = frs_pkg::CLS_NEWLINE;
			res.record_index = frs_pkg::out_sat(cur_index);
			st_next.in_header_line = 1'b0;
			st_next.at_line_start = 1'b1;
		end else if (data_byte == frs_pkg::CHAR_SPACE && st.at_line_start) begin
			res.byte_class = frs_pkg::CLS_SKIP;
			res.record_index = frs_pkg::out_sat(cur_index);
		end else if (data_byte == frs_pkg::CHAR_GT && st.at_line_start) begin
			res.byte_class = frs_pkg::CLS_START;
			if (st.record_open) begin
				res.closed_valid = 1'b1;
				res.closed_header_length = frs_pkg::out_sat(st.header_length);
				res.closed_sequence_length = frs_pkg::out_sat(st.sequence_length);
			end
			// index of the new record is the old count, clamped like the counter
			res.record_index = frs_pkg::out_sat(
				(st.record_counter == '1) ? st.record_counter - frs_pkg::cnt_t'(1)
				                          : st.record_counter);
			st_next.in_header_line = 1'b1;
			st_next.at_line_start = 1'b0;
			st_next.record_open = 1'b1;
			st_next.record_counter = frs_pkg::sat_inc(st.record_counter);
			st_next.header_length = '0;
			st_next.sequence_length = '0;
		end else if (!st.record_open) begin
			res.byte_class = frs_pkg::CLS_DROP;
		end else if (st.in_header_line) begin
			res.byte_class = frs_pkg::CLS_HEADER;
			res.record_index = frs_pkg::out_sat(cur_index);
			res.char_offset = frs_pkg::out_sat(st.header_length);
			st_next.header_length = frs_pkg::sat_inc(st.header_length);
		end else begin
			res.byte_class = frs_pkg::CLS_SEQ;
			res.record_index = frs_pkg::out_sat(cur_index);
			res.char_offset = frs_pkg::out_sat(st.sequence_length);
			st_next.sequence_length = frs_pkg::sat_inc(st.sequence_length);
		end
	end

endmodule

// ===== sv/frs_skid.sv =====
// Two-entry output buffer (result register plus skid register) for the splitter results.
// Depends on frs_pkg for the result type.
module frs_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  frs_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output frs_pkg::res_t out_res
);

	logic          main_valid_q;
	logic          skid_valid_q;
	frs_pkg::res_t main_q;
	frs_pkg::res_t skid_q;
	logic          push;
	logic          pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign push      = in_valid && in_ready;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_q <= in_res;
			else
				main_q <= in_res;
		end
	end

endmodule

// ===== sv/fasta_record_splitter.sv =====
// FASTA record splitter top level: parser state registers, classifier and output buffer.
// Depends on frs_pkg, frs_classify and frs_skid.
//
// Takes a FASTA text stream one byte per transaction and returns exactly one result
// transaction per input transaction. Each byte is classed as skipped space, newline,
// record start ('>'), header character, sequence character or dropped (anything before
// the first record). A '>' or space counts as a record start or skip only at the start
// of a line, and only a '>' clears that line-start flag, so inside sequence lines spaces
// are skipped anywhere and a '>' anywhere opens a new record. When a record closes, at
// the next record start or at the end marker (kind = 1), its header and sequence lengths
// come out with closed_valid set; the end marker also reports the record count and
// returns the parser to its reset state, ready for a new stream. Counters saturate.
// Throughput is one byte per clock while the consumer takes results: the classifier and
// all counter updates sit between the parser state registers and a result register, and
// a two-entry output buffer lets one more byte in while a result waits. out_valid comes
// from the registered result. in_ready drops only while both output entries are full.
module fasta_record_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  byte_class,
	output logic [7:0]  out_byte,
	output logic [31:0] record_index,
	output logic [31:0] char_offset,
	output logic        closed_valid,
	output logic [31:0] closed_header_length,
	output logic [31:0] closed_sequence_length,
	output logic [31:0] total_records
);

	frs_pkg::st_t  st_q;
	frs_pkg::st_t  st_next;
	frs_pkg::res_t res;
	frs_pkg::res_t out_res;
	logic          accept;

	assign accept = in_valid && in_ready;

	// classify the byte against the current flags and counters
	frs_classify u_classify (
		.st        (st_q),
		.kind      (kind),
		.data_byte (data_byte),
		.st_next   (st_next),
		.res       (res)
	);

	// advance parser state only on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= frs_pkg::ST_RESET;
		else if (accept)
			st_q <= st_next;
	end

	// hold results until the consumer takes them
	frs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_res    (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign byte_class             = out_res.byte_class;
	assign out_byte               = out_res.out_byte;
	assign record_index           = out_res.record_index;
	assign char_offset            = out_res.char_offset;
	assign closed_valid           = out_res.closed_valid;
	assign closed_header_length   = out_res.closed_header_length;
	assign closed_sequence_length = out_res.closed_sequence_length;
	assign total_records          = out_res.total_records;

endmodule

// ===== test/fasta_record_splitter_test.sv =====
// Self-checking testbench for fasta_record_splitter: directed byte table plus random FASTA text.
// Depends on frs_pkg and the fasta_record_splitter RTL; needs no other file.
module fasta_record_splitter_test;

	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 16;   // slack for any stray result to show up
	localparam int unsigned REPORT_LIMIT = 10;

	// One stimulus transaction. Where typed is set, want is the result written by hand;
	// otherwise the expected result comes from the byte predictor below.
	typedef struct packed {
		logic          is_end;
		logic [7:0]    data;
		logic          typed;
		frs_pkg::res_t want;
	} stim_row_t;

	// Directed table: reset state, byte extremes, every class, spaces and '>' inside header
	// and sequence lines, a '>' in the middle of a sequence line, end with and without an
	// open record, and bytes ahead of the first record.
	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{frs_pkg::KIND_END,  8'hA5, 1'b1,
			'{frs_pkg::CLS_END, 8'h00, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, 8'h00, 1'b1,
			'{frs_pkg::CLS_DROP, 8'h00, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, 8'hFF, 1'b1,
			'{frs_pkg::CLS_DROP, 8'hFF, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_SPACE, 1'b1,
			'{frs_pkg::CLS_SKIP, frs_pkg::CHAR_SPACE, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b1,
			'{frs_pkg::CLS_NEWLINE, frs_pkg::CHAR_NEWLINE, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_GT, 1'b1,
			'{frs_pkg::CLS_START, frs_pkg::CHAR_GT, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_SPACE,   1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_GT,      1'b0, '0},
		'{frs_pkg::KIND_DATA, 8'h78,                 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b0, '0},
		'{frs_pkg::KIND_DATA, 8'h41,                 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_SPACE,   1'b0, '0},
		'{frs_pkg::KIND_DATA, 8'h43,                 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_GT,      1'b0, '0},
		'{frs_pkg::KIND_DATA, 8'hFF,                 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b0, '0},
		'{frs_pkg::KIND_DATA, 8'h80,                 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b0, '0},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b0, '0},
		'{frs_pkg::KIND_END,  8'h47,                 1'b0, '0},
		'{frs_pkg::KIND_END,  8'hFF, 1'b1,
			'{frs_pkg::CLS_END, 8'h00, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, 8'h5A, 1'b1,
			'{frs_pkg::CLS_DROP, 8'h5A, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_GT, 1'b1,
			'{frs_pkg::CLS_START, frs_pkg::CHAR_GT, '0, '0, 1'b0, '0, '0, '0}},
		'{frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE, 1'b0, '0},
		'{frs_pkg::KIND_END,  frs_pkg::CHAR_GT,      1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  byte_class;
	logic [7:0]  out_byte;
	logic [31:0] record_index;
	logic [31:0] char_offset;
	logic        closed_valid;
	logic [31:0] closed_header_length;
	logic [31:0] closed_sequence_length;
	logic [31:0] total_records;

	fasta_record_splitter dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stim_row_t     stim_q[$];      // every transaction to send, directed rows first
	frs_pkg::res_t pend_q[$];      // results still owed by the block, oldest first
	int unsigned   accepted_count = 0;
	int unsigned   results_seen = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   phase = 0;      // 0: sender idles less, 1: receiver idles less, 2: no idling
	int unsigned   stall_at = 0;   // input transaction count that starts the long hold-off
	bit            stall_done = 1'b0;

	// Parser state as the predictor sees it.
	logic hdr_line, line_start, rec_open;
	frs_pkg::cnt_t rec_count, hdr_len, seq_len;

	function automatic frs_pkg::cnt_t bump(frs_pkg::cnt_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Clamp a counter into a 32-bit result field.
	function automatic frs_pkg::out_t clip_out(frs_pkg::cnt_t v);
		logic [63:0] wide;
		wide = 64'(v);
		return (wide > 64'hFFFF_FFFF) ? '1 : frs_pkg::out_t'(wide);
	endfunction

	function automatic frs_pkg::out_t open_index();
		return (rec_open && rec_count != '0) ? clip_out(rec_count - 1'b1) : '0;
	endfunction

	function automatic void restart_parser();
		hdr_line = 1'b0;
		line_start = 1'b1;
		rec_open = 1'b0;
		rec_count = '0;
		hdr_len = '0;
		seq_len = '0;
	endfunction

	// Classify one byte and advance the parser state. The line-start flag is set by every
	// newline and cleared only by the '>' that opens a record.
	function automatic frs_pkg::res_t parse_byte(logic k, logic [7:0] b);
		frs_pkg::res_t r;
		r = '0;
		r.out_byte = b;
		if (k == frs_pkg::KIND_END) begin
			r.byte_class = frs_pkg::CLS_END;
			r.out_byte = '0;
			if (rec_open) begin
				r.record_index = open_index();
				r.closed_valid = 1'b1;
				r.closed_header_length = clip_out(hdr_len);
				r.closed_sequence_length = clip_out(seq_len);
			end
			r.total_records = clip_out(rec_count);
			restart_parser();
		end else if (b == frs_pkg::CHAR_NEWLINE) begin
			r.byte_class = frs_pkg::CLS_NEWLINE;
			hdr_line = 1'b0;
			line_start = 1'b1;
			r.record_index = open_index();
		end else if (b == frs_pkg::CHAR_SPACE && line_start) begin
			r.byte_class = frs_pkg::CLS_SKIP;
			r.record_index = open_index();
		end else if (b == frs_pkg::CHAR_GT && line_start) begin
			r.byte_class = frs_pkg::CLS_START;
			hdr_line = 1'b1;
			line_start = 1'b0;
			if (rec_open) begin
				r.closed_valid = 1'b1;
				r.closed_header_length = clip_out(hdr_len);
				r.closed_sequence_length = clip_out(seq_len);
			end
			rec_count = bump(rec_count);
			rec_open = 1'b1;
			hdr_len = '0;
			seq_len = '0;
			r.record_index = open_index();
		end else if (!rec_open) begin
			r.byte_class = frs_pkg::CLS_DROP;
		end else if (hdr_line) begin
			r.byte_class = frs_pkg::CLS_HEADER;
			r.record_index = open_index();
			r.char_offset = clip_out(hdr_len);
			hdr_len = bump(hdr_len);
		end else begin
			r.byte_class = frs_pkg::CLS_SEQ;
			r.record_index = open_index();
			r.char_offset = clip_out(seq_len);
			seq_len = bump(seq_len);
		end
		return r;
	endfunction

	function automatic void add_item(logic k, logic [7:0] b);
		stim_row_t row;
		row = '{k, b, 1'b0, '0};
		stim_q.push_back(row);
	endfunction

	// Header or sequence text: mostly plain symbols, now and then a space, a '>' or a
	// byte with the top bit set.
	function automatic logic [7:0] text_byte(logic header);
		string       symbols;
		int unsigned pick;
		symbols = "ACGTNacgt";
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return frs_pkg::CHAR_GT;
		if (pick < 3)
			return frs_pkg::CHAR_SPACE;
		if (pick < 5)
			return 8'($urandom_range(128, 255));
		if (header)
			return 8'($urandom_range(8'h21, 8'h7E));
		return symbols[$urandom_range(0, symbols.len() - 1)];
	endfunction

	// Mostly well-formed records with random content, some end markers, some raw noise.
	task automatic build_random_stream(int unsigned count);
		int unsigned target, pick;
		target = stim_q.size() + count;
		while (stim_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_GT);
				repeat ($urandom_range(0, 12)) add_item(frs_pkg::KIND_DATA, text_byte(1'b1));
				add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE);
				repeat ($urandom_range(0, 3)) begin
					repeat ($urandom_range(0, 20))
						add_item(frs_pkg::KIND_DATA, text_byte(1'b0));
					// drop the line end now and then
					if ($urandom_range(0, 9) != 0)
						add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE);
				end
			end else if (pick < 85) begin
				add_item(frs_pkg::KIND_END, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 5))
						0: add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_NEWLINE);
						1: add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_SPACE);
						2: add_item(frs_pkg::KIND_DATA, frs_pkg::CHAR_GT);
						default: add_item(frs_pkg::KIND_DATA, 8'($urandom));
					endcase
				end
			end
		end
		// close the last record so its lengths and the total come out
		add_item(frs_pkg::KIND_END, 8'($urandom));
	endtask

	function automatic void compare_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("result %0d: %s expected 0x%08h, got 0x%08h",
					results_seen, field, want, got);
		end
	endfunction

	// Check one result transaction against the oldest expectation.
	task automatic take_result();
		frs_pkg::res_t want;
		results_seen++;
		if (pend_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("result %0d: unexpected, class %0d byte 0x%02h",
					results_seen, byte_class, out_byte);
			return;
		end
		want = pend_q.pop_front();
		compare_field("byte_class", 32'(byte_class), 32'(want.byte_class));
		compare_field("out_byte", 32'(out_byte), 32'(want.out_byte));
		compare_field("record_index", record_index, want.record_index);
		compare_field("char_offset", char_offset, want.char_offset);
		compare_field("closed_valid", 32'(closed_valid), 32'(want.closed_valid));
		compare_field("closed_header_length", closed_header_length,
			want.closed_header_length);
		compare_field("closed_sequence_length", closed_sequence_length,
			want.closed_sequence_length);
		compare_field("total_records", total_records, want.total_records);
	endtask

	// Sample both channels at the rising edge. Check results before queuing the
	// prediction for a new input: results are registered, so a result never belongs
	// to the transaction accepted at the same edge.
	always @(posedge clk) begin
		frs_pkg::res_t predicted;
		if (arst_n === 1'b1) begin
			if (out_valid === 1'b1 && out_ready)
				take_result();
			if (in_valid && in_ready === 1'b1) begin
				predicted = parse_byte(kind, data_byte);
				pend_q.push_back(stim_q[accepted_count].typed ?
					stim_q[accepted_count].want : predicted);
				accepted_count++;
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Abort a hung run.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Sender: reset, then walk the stimulus queue, one transaction per handshake.
	// Inputs change only at the falling edge.
	initial begin : sender
		int unsigned send_idle;
		int unsigned first_random, phase_len;
		stim_row_t   item;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = frs_pkg::KIND_DATA;
		data_byte = '0;
		restart_parser();
		foreach (DIRECTED_ROWS[j])
			stim_q.push_back(DIRECTED_ROWS[j]);
		first_random = stim_q.size();
		build_random_stream(RANDOM_ITEMS);
		phase_len = (stim_q.size() - first_random) / 3;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < stim_q.size(); i++) begin
			// Hold off until the block has drained: once after the directed rows and
			// once ahead of the no-idle phase.
			if (i == first_random || i == first_random + 2 * phase_len) begin
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (pend_q.size() != 0);
			end
			if (i >= first_random + 2 * phase_len) begin
				phase = 2;
				// arm the long receiver hold-off a little way into this phase
				if (stall_at == 0)
					stall_at = accepted_count + 30;
			end else if (i >= first_random + phase_len) begin
				phase = 1;
			end
			send_idle = (phase == 0) ? 33 : (phase == 1) ? 53 : 0;
			while ($urandom_range(0, 99) < send_idle) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			item = stim_q[i];
			in_valid <= 1'b1;
			kind <= item.is_end;
			data_byte <= item.data;
			// hold the transaction until it is taken
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;

		while (pend_q.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: random back-pressure per phase, plus one long hold-off while the
	// sender keeps offering bytes, so the output buffer fills and in_ready drops.
	initial begin : receiver
		int unsigned recv_idle;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!stall_done && stall_at != 0 && accepted_count >= stall_at) begin
				stall_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				recv_idle = (phase == 0) ? 53 : (phase == 1) ? 33 : 0;
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

endmodule

// ===== fasta_record_splitter.f =====
sv/frs_pkg.sv
sv/frs_classify.sv
sv/frs_skid.sv
sv/fasta_record_splitter.sv
test/fasta_record_splitter_test.sv
